@@ rtl/core/rla_pkg.sv @@
// Package for the ring linear attention block: item codes, status codes,
// register indexes and default sizes. No dependencies.
package rla_pkg;

   // Default sizes handed to the top level parameters.
   localparam int VEC_DIM_DEF      = 16;
   localparam int SLOTS_DEF        = 64;
   localparam int ELEMENT_BITS_DEF = 16;

   // Configuration register layout.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int DIMS_CFG_W  = 5;
   localparam int SLOTS_CFG_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_DIMS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS = 1'b1;
   localparam int DIMS_RESET  = 16;
   localparam int SLOTS_RESET = 64;

   // Item actions; the last code is accepted and ignored.
   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_NORM  = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_LEN   = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Result format and arithmetic constants.
   localparam int RES_W       = 20;
   localparam int IDX_W       = 4;
   localparam int RES_MAX     = 524287;
   localparam int RES_MIN_MAG = 524288;
   localparam int FRAC_SHIFT  = 24;
   localparam int Q_BITS      = 22;
   localparam int Q_CNT_W     = 5;
   localparam int COUNT_W     = 7;
   localparam int COUNT_MAX   = 127;

endpackage

@@ rtl/core/rla_div.sv @@
// Restoring divider for the attention normalization: one quotient bit per cycle.
// Depends on rla_pkg for the result width and saturation limits.
module rla_div
   import rla_pkg::*;
#(
   parameter int NUM_W = 60,
   parameter int DEN_W = 44
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic signed [DEN_W-1:0] divisor,
   output logic                    done,
   output logic signed [RES_W-1:0] quotient
);

   localparam int CMP_W = (NUM_W > DEN_W + Q_BITS - 1) ? NUM_W : DEN_W + Q_BITS - 1;

   logic                 run_ff;
   logic                 fin_ff;
   logic                 done_ff;
   logic [Q_CNT_W-1:0]   cnt_ff;
   logic [CMP_W-1:0]     rem_ff;
   logic [CMP_W-1:0]     dsh_ff;
   logic [Q_BITS-1:0]    quo_ff;
   logic                 neg_ff;
   logic signed [RES_W-1:0] res_ff;
   logic [NUM_W-1:0]     num_mag;
   logic [DEN_W-1:0]     den_mag;
   logic                 fits;

   // Magnitudes of the operands; the sign of the quotient is kept apart.
   always_comb begin
      num_mag = dividend[NUM_W-1] ? (~dividend + NUM_W'(1)) : dividend;
      den_mag = divisor[DEN_W-1] ? (~divisor + DEN_W'(1)) : divisor;
      fits    = (rem_ff >= dsh_ff);
   end

   // One compare and subtract per cycle, then a saturation step.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= Q_CNT_W'(Q_BITS);
            rem_ff <= CMP_W'(num_mag);
            dsh_ff <= CMP_W'(den_mag) << (Q_BITS - 1);
            quo_ff <= '0;
            neg_ff <= dividend[NUM_W-1] ^ divisor[DEN_W-1];
         end else if (run_ff) begin
            if (fits) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[Q_BITS-2:0], fits};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - Q_CNT_W'(1);
            if (cnt_ff == Q_CNT_W'(1)) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end
         // A set top bit means the quotient is far out of range.
         if (fin_ff) begin
            if (neg_ff) begin
               if (quo_ff > Q_BITS'(RES_MIN_MAG)) begin
                  res_ff <= RES_W'(RES_MIN_MAG);
               end else begin
                  res_ff <= RES_W'(-quo_ff);
               end
            end else begin
               if (quo_ff > Q_BITS'(RES_MAX)) begin
                  res_ff <= RES_W'(RES_MAX);
               end else begin
                  res_ff <= RES_W'(quo_ff);
               end
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

@@ rtl/core/ring_linear_attention.sv @@
// Top level of the ring linear attention block: item intake, vector bank
// memory, multiply-accumulate sequencer and result output. Uses rla_pkg, rla_div.

// A push element or a query element that is not the last of its vector is
// taken while busy stays low. The last element of a push vector then keeps
// busy high while the vector is written into the single-port bank memory. A
// query over N stored vectors of D elements keeps busy high for two passes
// over each vector, each element going through the bank read port and the
// one shared multiplier, then gives its D result items one after the other:
// directly when the weight sum is zero, otherwise each through the
// bit-serial divider. An empty bank gives D items. Results appear with
// rsp_valid for a single cycle and must be taken then; the block never waits
// for the receiver. Size registers take effect at the next clear item or
// reset.
module ring_linear_attention
   import rla_pkg::*;
#(
   parameter int VEC_DIM      = VEC_DIM_DEF,
   parameter int SLOTS        = SLOTS_DEF,
   parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_action,
   input  logic signed [ELEMENT_BITS-1:0] req_element_value,
   input  logic                           req_last_element,
   output logic                           rsp_valid,
   output logic signed [RES_W-1:0]        rsp_result_value,
   output logic [IDX_W-1:0]               rsp_result_index,
   output logic                           rsp_last_result,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_write_en,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_write_data
);

   localparam int EB     = ELEMENT_BITS;
   localparam int DIDX_W = (VEC_DIM > 1) ? $clog2(VEC_DIM) : 1;
   localparam int DCNT_W = $clog2(VEC_DIM + 1);
   localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCNT_W = $clog2(SLOTS + 1);
   localparam int ADDR_W = (SLOTS * VEC_DIM > 1) ? $clog2(SLOTS * VEC_DIM) : 1;
   localparam int W_W    = 2 * EB + $clog2(VEC_DIM + 1);
   localparam int ACC_W  = W_W + EB + $clog2(SLOTS + 1);
   localparam int TOT_W  = W_W + $clog2(SLOTS + 1);
   localparam int DIMS_RST  = (DIMS_RESET > VEC_DIM) ? VEC_DIM : DIMS_RESET;
   localparam int SLOTS_RST = (SLOTS_RESET > SLOTS) ? SLOTS : SLOTS_RESET;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(RES_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(RES_MIN_MAG);

   typedef enum logic [3:0] {
      S_IDLE, S_COMMIT, S_EMPTY, S_W_RD, S_W_MUL, S_W_ACC,
      S_A_RD, S_A_MUL, S_A_ACC, S_OUT, S_DIV_WAIT
   } state_type;

   state_type                    state_ff;
   logic [DIMS_CFG_W-1:0]        dims_cfg_ff;
   logic [SLOTS_CFG_W-1:0]       slots_cfg_ff;
   logic [DCNT_W-1:0]            act_dims_ff;
   logic [SCNT_W-1:0]            act_slots_ff;
   logic [SIDX_W-1:0]            ws_ff;
   logic [SCNT_W-1:0]            filled_ff;
   logic [COUNT_W-1:0]           incnt_ff;
   logic                         pend_query_ff;
   logic [DIDX_W-1:0]            dim_ff;
   logic [SIDX_W-1:0]            slot_ff;
   logic [SCNT_W-1:0]            iter_ff;
   logic signed [EB-1:0]         staging_ff [VEC_DIM];
   logic signed [EB-1:0]         query_ff   [VEC_DIM];
   logic signed [ACC_W-1:0]      acc_ff     [VEC_DIM];
   logic signed [W_W+EB-1:0]     prod_ff;
   logic signed [W_W-1:0]        w_ff;
   logic signed [TOT_W-1:0]      total_ff;
   logic                         rsp_valid_ff;
   logic signed [RES_W-1:0]      rsp_value_ff;
   logic [IDX_W-1:0]             rsp_index_ff;
   logic                         rsp_last_ff;
   logic [1:0]                   rsp_status_ff;

   logic signed [EB-1:0]         bank_mem [SLOTS*VEC_DIM];
   logic signed [EB-1:0]         bank_rdata_ff;
   logic [ADDR_W-1:0]            bank_addr;
   logic                         bank_we;

   logic                         accept;
   logic [DCNT_W-1:0]            dims_clamp;
   logic [SCNT_W-1:0]            slots_clamp;
   logic [COUNT_W-1:0]           cnt_base;
   logic [COUNT_W-1:0]           cnt_next;
   logic                         dim_last;
   logic [SCNT_W:0]              start_sum;
   logic [SIDX_W-1:0]            start_slot;
   logic [SIDX_W-1:0]            slot_adv;
   logic [SIDX_W-1:0]            ws_adv;
   logic signed [W_W-1:0]        mul_a;
   logic signed [W_W-1:0]        w_sum;
   logic signed [ACC_W-1:0]      acc_shift;
   logic signed [RES_W-1:0]      zero_res;
   logic                         total_nz;
   logic                         div_start;
   logic                         div_done;
   logic signed [RES_W-1:0]      div_res;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Size registers are clamped to the built sizes when latched.
   always_comb begin
      if (dims_cfg_ff == '0) begin
         dims_clamp = DCNT_W'(1);
      end else if (32'(dims_cfg_ff) > 32'(VEC_DIM)) begin
         dims_clamp = DCNT_W'(VEC_DIM);
      end else begin
         dims_clamp = DCNT_W'(dims_cfg_ff);
      end
      if (slots_cfg_ff == '0) begin
         slots_clamp = SCNT_W'(1);
      end else if (32'(slots_cfg_ff) > 32'(SLOTS)) begin
         slots_clamp = SCNT_W'(SLOTS);
      end else begin
         slots_clamp = SCNT_W'(slots_cfg_ff);
      end
   end

   // Element count of the vector in progress; a change of kind restarts it.
   always_comb begin
      if ((incnt_ff != '0) && (pend_query_ff != (req_action == ACT_QUERY))) begin
         cnt_base = '0;
      end else begin
         cnt_base = incnt_ff;
      end
      cnt_next = (cnt_base < COUNT_W'(COUNT_MAX)) ? cnt_base + COUNT_W'(1) : cnt_base;
   end

   // Ring slot arithmetic: oldest stored slot and wrapping increments.
   always_comb begin
      start_sum = (SCNT_W+1)'(ws_ff) + (SCNT_W+1)'(act_slots_ff) - (SCNT_W+1)'(filled_ff);
      if (start_sum >= (SCNT_W+1)'(act_slots_ff)) begin
         start_sum = start_sum - (SCNT_W+1)'(act_slots_ff);
      end
      start_slot = SIDX_W'(start_sum);
      slot_adv = (SCNT_W'(slot_ff) + SCNT_W'(1) == act_slots_ff) ? '0 : slot_ff + SIDX_W'(1);
      ws_adv   = (SCNT_W'(ws_ff) + SCNT_W'(1) == act_slots_ff) ? '0 : ws_ff + SIDX_W'(1);
      dim_last = (DCNT_W'(dim_ff) == act_dims_ff - DCNT_W'(1));
      w_sum    = w_ff + W_W'(prod_ff);
      total_nz = (total_ff != '0);
   end

   // The one multiplier takes the query element in the first pass and the
   // vector weight in the second.
   always_comb begin
      if (state_ff == S_W_MUL) begin
         mul_a = W_W'(query_ff[dim_ff]);
      end else begin
         mul_a = w_ff;
      end
   end

   // Zero weight sum: floor shift back to the result scale, saturated.
   always_comb begin
      acc_shift = acc_ff[dim_ff] >>> FRAC_SHIFT;
      if (acc_shift > SAT_HI) begin
         zero_res = RES_W'(RES_MAX);
      end else if (acc_shift < SAT_LO) begin
         zero_res = RES_W'(RES_MIN_MAG);
      end else begin
         zero_res = RES_W'(acc_shift);
      end
   end

   // Bank memory: one port, shared by the commit and the query passes.
   assign bank_we   = (state_ff == S_COMMIT);
   assign bank_addr = ADDR_W'((bank_we ? ws_ff : slot_ff)) * ADDR_W'(VEC_DIM)
                      + ADDR_W'(dim_ff);

   always_ff @(posedge clock) begin
      if (bank_we) begin
         bank_mem[bank_addr] <= staging_ff[dim_ff];
      end
      bank_rdata_ff <= bank_mem[bank_addr];
   end

   assign div_start = (state_ff == S_OUT) && total_nz;

   rla_div #(
      .NUM_W (ACC_W),
      .DEN_W (TOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff[dim_ff]),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_res)
   );

   // Sequencer: intake, commit, two multiply-accumulate passes, output.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dims_cfg_ff   <= DIMS_CFG_W'(DIMS_RESET);
         slots_cfg_ff  <= SLOTS_CFG_W'(SLOTS_RESET);
         act_dims_ff   <= DCNT_W'(DIMS_RST);
         act_slots_ff  <= SCNT_W'(SLOTS_RST);
         ws_ff         <= '0;
         filled_ff     <= '0;
         incnt_ff      <= '0;
         pend_query_ff <= 1'b0;
         dim_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_write_en) begin
            if (csr_index == REG_DIMS) begin
               dims_cfg_ff <= DIMS_CFG_W'(csr_write_data);
            end else if (csr_index == REG_SLOTS) begin
               slots_cfg_ff <= SLOTS_CFG_W'(csr_write_data);
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_action == ACT_CLEAR) begin
                     ws_ff        <= '0;
                     filled_ff    <= '0;
                     incnt_ff     <= '0;
                     act_dims_ff  <= dims_clamp;
                     act_slots_ff <= slots_clamp;
                  end else if ((req_action == ACT_PUSH) || (req_action == ACT_QUERY)) begin
                     pend_query_ff <= (req_action == ACT_QUERY);
                     if (cnt_base < COUNT_W'(act_dims_ff)) begin
                        if (req_action == ACT_PUSH) begin
                           staging_ff[DIDX_W'(cnt_base)] <= req_element_value;
                        end else begin
                           query_ff[DIDX_W'(cnt_base)] <= req_element_value;
                        end
                     end
                     if (!req_last_element) begin
                        incnt_ff <= cnt_next;
                     end else begin
                        incnt_ff <= '0;
                        dim_ff   <= '0;
                        if (cnt_next != COUNT_W'(act_dims_ff)) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_value_ff  <= '0;
                           rsp_index_ff  <= '0;
                           rsp_last_ff   <= 1'b1;
                           rsp_status_ff <= ST_LEN;
                        end else if (req_action == ACT_PUSH) begin
                           state_ff <= S_COMMIT;
                        end else if (filled_ff == '0) begin
                           state_ff <= S_EMPTY;
                        end else begin
                           for (int d = 0; d < VEC_DIM; d++) begin
                              acc_ff[d] <= '0;
                           end
                           total_ff <= '0;
                           w_ff     <= '0;
                           slot_ff  <= start_slot;
                           iter_ff  <= filled_ff;
                           state_ff <= S_W_RD;
                        end
                     end
                  end
               end
            end
            S_COMMIT: begin
               if (dim_last) begin
                  ws_ff    <= ws_adv;
                  dim_ff   <= '0;
                  state_ff <= S_IDLE;
                  if (filled_ff < act_slots_ff) begin
                     filled_ff <= filled_ff + SCNT_W'(1);
                  end
               end else begin
                  dim_ff <= dim_ff + DIDX_W'(1);
               end
            end
            S_EMPTY: begin
               rsp_valid_ff  <= 1'b1;
               rsp_value_ff  <= '0;
               rsp_index_ff  <= IDX_W'(dim_ff);
               rsp_last_ff   <= dim_last;
               rsp_status_ff <= ST_EMPTY;
               if (dim_last) begin
                  dim_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  dim_ff <= dim_ff + DIDX_W'(1);
               end
            end
            // First pass: weight of this stored vector against the query.
            S_W_RD: begin
               state_ff <= S_W_MUL;
            end
            S_W_MUL: begin
               prod_ff  <= mul_a * bank_rdata_ff;
               state_ff <= S_W_ACC;
            end
            S_W_ACC: begin
               w_ff <= w_sum;
               if (dim_last) begin
                  total_ff <= total_ff + TOT_W'(w_sum);
                  dim_ff   <= '0;
                  state_ff <= S_A_RD;
               end else begin
                  dim_ff   <= dim_ff + DIDX_W'(1);
                  state_ff <= S_W_RD;
               end
            end
            // Second pass: weighted vector into the accumulators.
            S_A_RD: begin
               state_ff <= S_A_MUL;
            end
            S_A_MUL: begin
               prod_ff  <= mul_a * bank_rdata_ff;
               state_ff <= S_A_ACC;
            end
            S_A_ACC: begin
               acc_ff[dim_ff] <= acc_ff[dim_ff] + ACC_W'(prod_ff);
               if (dim_last) begin
                  dim_ff <= '0;
                  w_ff   <= '0;
                  if (iter_ff == SCNT_W'(1)) begin
                     state_ff <= S_OUT;
                  end else begin
                     iter_ff  <= iter_ff - SCNT_W'(1);
                     slot_ff  <= slot_adv;
                     state_ff <= S_W_RD;
                  end
               end else begin
                  dim_ff   <= dim_ff + DIDX_W'(1);
                  state_ff <= S_A_RD;
               end
            end
            // Output: divide by the weight sum, or shift when it is zero.
            S_OUT: begin
               if (total_nz) begin
                  state_ff <= S_DIV_WAIT;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= zero_res;
                  rsp_index_ff  <= IDX_W'(dim_ff);
                  rsp_last_ff   <= dim_last;
                  rsp_status_ff <= ST_ZERO;
                  if (dim_last) begin
                     dim_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     dim_ff <= dim_ff + DIDX_W'(1);
                  end
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= div_res;
                  rsp_index_ff  <= IDX_W'(dim_ff);
                  rsp_last_ff   <= dim_last;
                  rsp_status_ff <= ST_NORM;
                  if (dim_last) begin
                     dim_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     dim_ff   <= dim_ff + DIDX_W'(1);
                     state_ff <= S_OUT;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

   // The ring never holds more vectors than the latched slot count.
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      (filled_ff <= act_slots_ff) && (SCNT_W'(ws_ff) < act_slots_ff))
      else $error("ring fill or write slot out of range");

   // The last item of a run always leaves the sequencer idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> (state_ff == S_IDLE))
      else $error("last result given while sequencer still busy");

   // The divider only finishes while the sequencer waits for it.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider result with no query waiting");

   // A clear item empties the ring.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_CLEAR)) |=> ((filled_ff == '0) && (ws_ff == '0)))
      else $error("clear item did not empty the ring");

endmodule

@@ tb/ring_linear_attention_tb.sv @@
// Self-checking testbench for ring_linear_attention: a scoreboard class with a
// bit-exact predictor of the bank and query arithmetic, plus driving tasks.
// Depends on rla_pkg and the ring_linear_attention top level.
module ring_linear_attention_tb;
   import rla_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic signed [RES_W-1:0] value;
      logic [IDX_W-1:0]        index;
      logic                    last;
      logic [1:0]              status;
   } attn_result_type;

   // Scoreboard: predicts the results of each accepted item and checks them.
   class attn_scoreboard_type;
      longint          bank_words [SLOTS_DEF*VEC_DIM_DEF];
      longint          staged_key [VEC_DIM_DEF];
      longint          query_key  [VEC_DIM_DEF];
      int              ring_slot, filled, elem_count;
      int              dims_reg, slots_reg, dims_live, slots_live;
      logic [1:0]      vector_kind;
      attn_result_type pending_results [$];
      int              errors;

      function new();
         dims_reg = DIMS_RESET;
         slots_reg = SLOTS_RESET;
         vector_kind = ACT_PUSH;
         errors = 0;
         empty_bank();
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      // Sizes are clamped and latched only at a clear or reset.
      function void empty_bank();
         ring_slot = 0;
         filled = 0;
         elem_count = 0;
         dims_live = (dims_reg < 1) ? 1 : (dims_reg > VEC_DIM_DEF) ? VEC_DIM_DEF : dims_reg;
         slots_live = (slots_reg < 1) ? 1 : (slots_reg > SLOTS_DEF) ? SLOTS_DEF : slots_reg;
      endfunction

      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_DIMS) dims_reg = data[DIMS_CFG_W-1:0];
         else if (idx == REG_SLOTS) slots_reg = data[SLOTS_CFG_W-1:0];
      endfunction

      function void add_result(longint value, int idx, bit last, logic [1:0] status);
         attn_result_type r;
         r.value = value[RES_W-1:0];
         r.index = idx[IDX_W-1:0];
         r.last = last;
         r.status = status;
         pending_results.push_back(r);
      endfunction

      function longint clip(longint v);
         if (v > RES_MAX) return RES_MAX;
         if (v < -RES_MIN_MAG) return -RES_MIN_MAG;
         return v;
      endfunction

      // Weighted sum over the stored vectors, oldest first.
      function void predict_query();
         longint acc [VEC_DIM_DEF];
         longint wsum, w, a;
         int slot;
         if (filled == 0) begin
            for (int d = 0; d < dims_live; d++) add_result(0, d, d + 1 == dims_live, ST_EMPTY);
            return;
         end
         wsum = 0;
         for (int d = 0; d < VEC_DIM_DEF; d++) acc[d] = 0;
         for (int i = 0; i < filled; i++) begin
            slot = (ring_slot + slots_live - filled + i) % slots_live;
            w = 0;
            for (int d = 0; d < dims_live; d++)
               w += query_key[d] * bank_words[slot*VEC_DIM_DEF + d];
            wsum += w;
            for (int d = 0; d < dims_live; d++)
               acc[d] += w * bank_words[slot*VEC_DIM_DEF + d];
         end
         for (int d = 0; d < dims_live; d++) begin
            a = acc[d];
            if (wsum != 0) add_result(clip(a / wsum), d, d + 1 == dims_live, ST_NORM);
            else add_result(clip(a >>> FRAC_SHIFT), d, d + 1 == dims_live, ST_ZERO);
         end
      endfunction

      function void note_item(logic [1:0] action, logic signed [15:0] value, logic last);
         int n;
         if (action == ACT_CLEAR) begin
            empty_bank();
            return;
         end
         if (action != ACT_PUSH && action != ACT_QUERY) return;
         // A change of kind mid-vector silently drops the partial vector.
         if (elem_count > 0 && vector_kind != action) elem_count = 0;
         vector_kind = action;
         if (elem_count < dims_live) begin
            if (action == ACT_PUSH) staged_key[elem_count] = longint'(value);
            else query_key[elem_count] = longint'(value);
         end
         if (elem_count < COUNT_MAX) elem_count++;
         if (!last) return;
         n = elem_count;
         elem_count = 0;
         if (n != dims_live) begin
            add_result(0, 0, 1'b1, ST_LEN);
         end else if (action == ACT_PUSH) begin
            for (int d = 0; d < dims_live; d++)
               bank_words[ring_slot*VEC_DIM_DEF + d] = staged_key[d];
            ring_slot = (ring_slot + 1) % slots_live;
            if (filled < slots_live) filled++;
         end else begin
            predict_query();
         end
      endfunction

      task check_result(attn_result_type got);
         attn_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result value %0d index %0d", got.value, got.index));
            return;
         end
         want = pending_results.pop_front();
         if (got.value !== want.value)
            report($sformatf("value %0d, expected %0d", got.value, want.value));
         if (got.index !== want.index)
            report($sformatf("index %0d, expected %0d", got.index, want.index));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_action = ACT_PUSH;
   logic signed [15:0]      req_element_value = '0;
   logic                    req_last_element = 1'b0;
   logic                    rsp_valid;
   logic signed [RES_W-1:0] rsp_result_value;
   logic [IDX_W-1:0]        rsp_result_index;
   logic                    rsp_last_result;
   logic [1:0]              rsp_status;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = REG_DIMS;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   attn_scoreboard_type attn_sb = new();
   int                  idle_pct = 0;
   int                  cycles = 0;
   int                  cur_dims = DIMS_RESET;

   ring_linear_attention dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_element_value(req_element_value),
      .req_last_element(req_last_element), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value), .rsp_result_index(rsp_result_index),
      .rsp_last_result(rsp_last_result), .rsp_status(rsp_status),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Monitor: check results first, then predict the item taken at this edge.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ring_linear_attention verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid)
            attn_sb.check_result({rsp_result_value, rsp_result_index, rsp_last_result,
                                  rsp_status});
         if (csr_write_en) attn_sb.write_csr(csr_index, csr_write_data);
         if (start && !busy) attn_sb.note_item(req_action, req_element_value, req_last_element);
      end
   end

   // Offer one item, with random idle cycles first, and hold it until taken.
   task automatic send_item(logic [1:0] action, logic [15:0] value, logic last);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_action = action;
      req_element_value = value;
      req_last_element = last;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Wait until every predicted result has come and the block is idle.
   task automatic drain();
      start = 1'b0;
      while (attn_sb.pending_results.size() != 0 || busy) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Write both size registers and latch them with a clear item.
   task automatic set_sizes(int dims, int slots);
      drain();
      csr_write(REG_DIMS, dims[CSR_DATA_W-1:0]);
      csr_write(REG_SLOTS, slots[CSR_DATA_W-1:0]);
      send_item(ACT_CLEAR, 16'($urandom), 1'($urandom_range(1)));
      cur_dims = (dims < 1) ? 1 : (dims > VEC_DIM_DEF) ? VEC_DIM_DEF : dims;
   endtask

   function automatic logic [15:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return 16'($urandom);
      if (sel < 75) return 16'(($urandom_range(2) - 1) << 12);
      if (sel < 88) return 16'($urandom_range(16) - 8);
      return $urandom_range(1) ? 16'h7FFF : 16'h8000;
   endfunction

   // One vector of the given kind; a wrong length or a noise item now and then.
   task automatic send_vector(logic [1:0] kind);
      int len, sel;
      len = cur_dims;
      sel = $urandom_range(99);
      if (sel < 8) len = (cur_dims > 1 && $urandom_range(1)) ? cur_dims - 1 : cur_dims + 1;
      else if (sel < 12) begin
         repeat ($urandom_range(1, 3)) send_item(kind ^ 2'b01, pick_value(), 1'b0);
      end else if (sel < 14) send_item(ACT_NOP, 16'($urandom), 1'($urandom_range(1)));
      for (int i = 0; i < len; i++) send_item(kind, pick_value(), i == len - 1);
   endtask

   task automatic random_phase(int items, int idle);
      int sent;
      idle_pct = idle;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 2) begin
            send_item(ACT_CLEAR, 16'($urandom), 1'($urandom_range(1)));
            sent++;
         end else begin
            send_vector(($urandom_range(99) < 65) ? ACT_PUSH : ACT_QUERY);
            sent += cur_dims;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: tiny bank with one element per vector.
      set_sizes(0, 2);
      send_item(ACT_QUERY, 16'h7FFF, 1'b1);
      send_item(ACT_PUSH, 16'h1000, 1'b1);
      send_item(ACT_PUSH, 16'hF000, 1'b1);
      send_item(ACT_QUERY, 16'h1000, 1'b1);
      send_item(ACT_PUSH, 16'h8000, 1'b1);
      send_item(ACT_QUERY, 16'h7FFF, 1'b1);
      send_item(ACT_QUERY, 16'h8000, 1'b1);
      send_item(ACT_QUERY, 16'h0000, 1'b1);
      send_item(ACT_PUSH, 16'h0001, 1'b0);
      send_item(ACT_PUSH, 16'h0002, 1'b1);
      send_item(ACT_QUERY, 16'h0003, 1'b0);
      send_item(ACT_PUSH, 16'h7FFF, 1'b1);
      send_item(ACT_NOP, 16'h5555, 1'b1);
      send_item(ACT_QUERY, 16'hFFFF, 1'b1);

      // Directed: oversize register values clamp to the largest sizes.
      set_sizes(31, 127);
      for (int i = 0; i < cur_dims; i++) send_item(ACT_QUERY, 16'h0000, i == cur_dims - 1);

      // Random phases over several size settings and idle rates.
      set_sizes(4, 8);
      random_phase(115, 32);
      set_sizes(16, 64);
      random_phase(115, 81);
      set_sizes(1, 1);
      random_phase(115, 0);
      set_sizes(7, 33);
      random_phase(115, 0);

      drain();
      if (attn_sb.errors == 0 && attn_sb.pending_results.size() == 0) begin
         $display("ring_linear_attention verification clean");
      end else begin
         $display("ring_linear_attention verification failed");
      end
      $finish;
   end

endmodule
